FILE: src/ars_pkg.sv
// Shared types and constants for the address range set table.
package ars_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDRESS_BITS  = 64;
    localparam int FIELD_W       = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int RESCAN_CAP    = 4 * TABLE_ENTRIES + 4;
    localparam int PASS_W        = $clog2(RESCAN_CAP);

    typedef logic [ADDRESS_BITS-1:0]  addr_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [PASS_W-1:0]        pass_t;
    typedef logic [TABLE_ENTRIES-1:0] valid_vec_t;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_SUB   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_SIZE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_NOCHG = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_APPEND,
        ST_SUB,
        ST_QUERY,
        ST_SIZE,
        ST_DONE
    } state_t;

    // Result of the shared compare unit for one entry
    typedef struct packed {
        logic  add_match;
        logic  add_chg;
        addr_t add_ns;
        addr_t add_ne;
        logic  sub_trim_end;
        logic  sub_trim_start;
        logic  sub_del;
        logic  sub_split;
        logic  hit;
        addr_t diff;
    } cmp_res_t;

    // Table write request
    typedef struct packed {
        logic  start_we;
        logic  end_we;
        idx_t  idx;
        addr_t start_d;
        addr_t end_d;
        logic  set_valid;
        logic  clr_valid;
    } tbl_wr_t;

endpackage

FILE: src/ars_cmp.sv
// Shared compare unit: evaluates one table entry against the working range.
module ars_cmp (
    input  ars_pkg::addr_t    ent_start,
    input  ars_pkg::addr_t    ent_end,
    input  ars_pkg::addr_t    op_lo,
    input  ars_pkg::addr_t    op_hi,
    output ars_pkg::cmp_res_t res
);
    import ars_pkg::*;

    logic s_lt_lo, s_eq_lo, s_lt_hi, s_eq_hi;
    logic e_lt_lo, e_eq_lo, e_lt_hi, e_eq_hi;
    logic s_le_lo, s_ge_lo, s_gt_lo, s_le_hi, s_lt_hi_s;
    logic e_ge_lo, e_gt_lo, e_le_hi, e_ge_hi, e_gt_hi;

    assign s_lt_lo = ent_start < op_lo;
    assign s_eq_lo = ent_start == op_lo;
    assign s_lt_hi = ent_start < op_hi;
    assign s_eq_hi = ent_start == op_hi;
    assign e_lt_lo = ent_end < op_lo;
    assign e_eq_lo = ent_end == op_lo;
    assign e_lt_hi = ent_end < op_hi;
    assign e_eq_hi = ent_end == op_hi;

    assign s_le_lo   = s_lt_lo | s_eq_lo;
    assign s_ge_lo   = ~s_lt_lo;
    assign s_gt_lo   = ~s_lt_lo & ~s_eq_lo;
    assign s_le_hi   = s_lt_hi | s_eq_hi;
    assign s_lt_hi_s = s_lt_hi;
    assign e_ge_lo   = ~e_lt_lo;
    assign e_gt_lo   = ~e_lt_lo & ~e_eq_lo;
    assign e_le_hi   = e_lt_hi | e_eq_hi;
    assign e_ge_hi   = ~e_lt_hi;
    assign e_gt_hi   = ~e_lt_hi & ~e_eq_hi;

    always_comb begin
        res = '0;
        res.add_ns = ent_start;
        res.add_ne = ent_end;
        priority if (s_eq_lo && e_eq_hi) begin
            res.add_match = 1'b1;
        end else if (s_le_lo && s_le_hi && e_ge_lo && e_le_hi) begin
            res.add_ne    = op_hi;
            res.add_match = 1'b1;
        end else if (s_ge_lo && s_le_hi && e_ge_lo && e_ge_hi) begin
            res.add_ns    = op_lo;
            res.add_match = 1'b1;
        end else if (s_le_lo && s_le_hi && e_ge_lo && e_ge_hi) begin
            res.add_match = 1'b1;
        end else if (s_ge_lo && s_le_hi && e_ge_lo && e_le_hi) begin
            res.add_ns    = op_lo;
            res.add_ne    = op_hi;
            res.add_match = 1'b1;
        end else begin
            res.add_match = 1'b0;
        end
        res.add_chg = (res.add_ns != ent_start) || (res.add_ne != ent_end);

        res.sub_trim_end   = s_lt_lo && s_lt_hi_s && e_gt_lo && e_lt_hi;
        res.sub_trim_start = s_gt_lo && s_lt_hi_s && e_gt_lo && e_gt_hi;
        res.sub_del        = s_gt_lo && s_lt_hi_s && e_gt_lo && e_lt_hi;
        res.sub_split      = s_lt_lo && s_lt_hi_s && e_gt_lo && e_gt_hi;

        res.hit  = s_le_lo && e_ge_lo;
        res.diff = ent_end - ent_start;
    end

endmodule

FILE: src/ars_tbl.sv
// Range storage: bound memories with registered read, valid flags and fill count.
module ars_tbl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  ars_pkg::idx_t       rd_idx,
    input  ars_pkg::tbl_wr_t    wr,
    output ars_pkg::addr_t      rd_start,
    output ars_pkg::addr_t      rd_end,
    output ars_pkg::valid_vec_t valid,
    output ars_pkg::cnt_t       count
);
    import ars_pkg::*;

    addr_t      start_mem [TABLE_ENTRIES];
    addr_t      end_mem   [TABLE_ENTRIES];
    addr_t      rd_start_reg, rd_end_reg;
    valid_vec_t valid_reg, valid_next;
    cnt_t       count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (wr.start_we) begin
            start_mem[wr.idx] <= wr.start_d;
        end
        if (wr.end_we) begin
            end_mem[wr.idx] <= wr.end_d;
        end
        if (rd_en) begin
            rd_start_reg <= start_mem[rd_idx];
            rd_end_reg   <= end_mem[rd_idx];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (wr.set_valid) begin
            valid_next[wr.idx] = 1'b1;
            count_next         = count_reg + cnt_t'(1);
        end else if (wr.clr_valid) begin
            valid_next[wr.idx] = 1'b0;
            count_next         = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign rd_start = rd_start_reg;
    assign rd_end   = rd_end_reg;
    assign valid    = valid_reg;
    assign count    = count_reg;

endmodule

FILE: src/address_range_set_table.sv
// Top level of the address range set table: sequencer, operands and result register.
//
// The block keeps a table of TABLE_ENTRIES address ranges [start, end] and
// takes one operation per input beat: add (bounds ordered first, then merged
// into overlapping entries or appended to the lowest free slot), subtract
// (trim, delete strictly enclosed entries, split a strictly enclosing entry
// and re-add its upper piece), query (end inclusive) and size (wrapping sum
// of end minus start). One result beat comes back per input beat. Work is
// done by a single compare unit that visits the table one slot at a time;
// the bound memories have a registered read port, so an occupied slot is
// read in one step and compared in a second, while an empty slot is skipped
// without a read. Every add ends with its append step, whether or not it
// appends. A subtract restarts its scan from slot 0 after every delete or
// split (a split also runs a full add scan), bounded by 4*TABLE_ENTRIES+4
// passes. s_ready is high only while the sequencer is idle; a finished
// result waits in the output register while the next beat is taken. No
// clearing pass is needed after reset: only the valid flags and the fill
// count are cleared.
module address_range_set_table (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [63:0]          s_range_start,
    input  logic [63:0]          s_range_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [1:0]           m_status,
    output logic [63:0]          m_total_size,
    output ars_pkg::cnt_t        m_entries_used
);
    import ars_pkg::*;

    state_t  state_reg, state_next;
    action_t act_reg, act_next;
    idx_t    idx_reg, idx_next;
    logic    ph_reg, ph_next;
    pass_t   pass_reg, pass_next;
    logic    match_reg, match_next;
    logic    chg_reg, chg_next;
    logic    drop_reg, drop_next;
    logic    free_ok_reg, free_ok_next;
    idx_t    free_idx_reg, free_idx_next;
    logic    nest_reg, nest_next;
    logic    hit_reg, hit_next;
    addr_t   size_reg, size_next;
    addr_t   lo_reg, lo_next;
    addr_t   hi_reg, hi_next;
    addr_t   nlo_reg, nlo_next;
    addr_t   nhi_reg, nhi_next;

    logic    m_valid_reg, m_valid_next;
    logic    m_hit_reg, m_hit_next;
    status_t m_status_reg, m_status_next;
    addr_t   m_size_reg, m_size_next;
    cnt_t    m_used_reg, m_used_next;

    logic       rd_en;
    tbl_wr_t    wr;
    addr_t      rd_start, rd_end;
    valid_vec_t valid;
    cnt_t       count;
    cmp_res_t   cmp;
    addr_t      op_lo, op_hi;
    addr_t      in_a, in_b;
    logic       last;

    ars_tbl u_tbl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_idx   (idx_reg),
        .wr       (wr),
        .rd_start (rd_start),
        .rd_end   (rd_end),
        .valid    (valid),
        .count    (count)
    );

    // The nested add of a split works on the upper piece
    assign op_lo = nest_reg ? nlo_reg : lo_reg;
    assign op_hi = nest_reg ? nhi_reg : hi_reg;

    ars_cmp u_cmp (
        .ent_start (rd_start),
        .ent_end   (rd_end),
        .op_lo     (op_lo),
        .op_hi     (op_hi),
        .res       (cmp)
    );

    assign in_a = addr_t'(s_range_start);
    assign in_b = addr_t'(s_range_end);
    assign last = idx_reg == idx_t'(TABLE_ENTRIES - 1);

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        idx_next      = idx_reg;
        ph_next       = ph_reg;
        pass_next     = pass_reg;
        match_next    = match_reg;
        chg_next      = chg_reg;
        drop_next     = drop_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        nest_next     = nest_reg;
        hit_next      = hit_reg;
        size_next     = size_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        nlo_next      = nlo_reg;
        nhi_next      = nhi_reg;
        m_valid_next  = m_valid_reg;
        m_hit_next    = m_hit_reg;
        m_status_next = m_status_reg;
        m_size_next   = m_size_reg;
        m_used_next   = m_used_reg;
        rd_en         = 1'b0;
        wr            = '0;
        wr.idx        = idx_reg;

        // Drop the result beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = action_t'(s_action);
                    idx_next     = '0;
                    ph_next      = 1'b0;
                    pass_next    = '0;
                    match_next   = 1'b0;
                    chg_next     = 1'b0;
                    drop_next    = 1'b0;
                    free_ok_next = 1'b0;
                    nest_next    = 1'b0;
                    hit_next     = 1'b0;
                    size_next    = '0;
                    lo_next      = (in_a < in_b) ? in_a : in_b;
                    hi_next      = (in_a < in_b) ? in_b : in_a;
                    unique case (action_t'(s_action))
                        ACT_ADD: begin
                            state_next = ST_ADD;
                        end
                        ACT_SUB: begin
                            // Empty range: nothing to take away
                            state_next = (in_a == in_b) ? ST_DONE : ST_SUB;
                        end
                        ACT_QUERY: begin
                            lo_next    = in_a;
                            hi_next    = in_a;
                            state_next = ST_QUERY;
                        end
                        ACT_SIZE: begin
                            state_next = ST_SIZE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD: begin
                if (!ph_reg) begin
                    if (valid[idx_reg]) begin
                        rd_en   = 1'b1;
                        ph_next = 1'b1;
                    end else begin
                        // Remember the lowest free slot for the append
                        if (!free_ok_reg) begin
                            free_ok_next  = 1'b1;
                            free_idx_next = idx_reg;
                        end
                        idx_next   = last ? '0 : idx_reg + idx_t'(1);
                        state_next = last ? ST_APPEND : ST_ADD;
                    end
                end else begin
                    wr.start_we = cmp.add_chg;
                    wr.end_we   = cmp.add_chg;
                    wr.start_d  = cmp.add_ns;
                    wr.end_d    = cmp.add_ne;
                    match_next  = match_reg | cmp.add_match;
                    chg_next    = chg_reg | cmp.add_chg;
                    ph_next     = 1'b0;
                    idx_next    = last ? '0 : idx_reg + idx_t'(1);
                    state_next  = last ? ST_APPEND : ST_ADD;
                end
            end

            ST_APPEND: begin
                if (!match_reg) begin
                    if (free_ok_reg) begin
                        wr.idx       = free_idx_reg;
                        wr.start_we  = 1'b1;
                        wr.end_we    = 1'b1;
                        wr.start_d   = op_lo;
                        wr.end_d     = op_hi;
                        wr.set_valid = 1'b1;
                        chg_next     = 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                end
                idx_next = '0;
                ph_next  = 1'b0;
                if (nest_reg) begin
                    // Back to the subtract scan from slot 0
                    nest_next = 1'b0;
                    if (pass_reg < pass_t'(RESCAN_CAP - 1)) begin
                        pass_next  = pass_reg + pass_t'(1);
                        state_next = ST_SUB;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_SUB: begin
                if (!ph_reg) begin
                    if (valid[idx_reg]) begin
                        rd_en   = 1'b1;
                        ph_next = 1'b1;
                    end else begin
                        idx_next   = last ? '0 : idx_reg + idx_t'(1);
                        state_next = last ? ST_DONE : ST_SUB;
                    end
                end else begin
                    ph_next = 1'b0;
                    priority if (cmp.sub_trim_end) begin
                        wr.end_we  = 1'b1;
                        wr.end_d   = lo_reg;
                        chg_next   = 1'b1;
                        idx_next   = last ? '0 : idx_reg + idx_t'(1);
                        state_next = last ? ST_DONE : ST_SUB;
                    end else if (cmp.sub_trim_start) begin
                        wr.start_we = 1'b1;
                        wr.start_d  = hi_reg;
                        chg_next    = 1'b1;
                        idx_next    = last ? '0 : idx_reg + idx_t'(1);
                        state_next  = last ? ST_DONE : ST_SUB;
                    end else if (cmp.sub_del) begin
                        wr.clr_valid = 1'b1;
                        chg_next     = 1'b1;
                        idx_next     = '0;
                        if (pass_reg < pass_t'(RESCAN_CAP - 1)) begin
                            pass_next  = pass_reg + pass_t'(1);
                            state_next = ST_SUB;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (cmp.sub_split) begin
                        // Keep the lower piece, re-add the upper one
                        wr.end_we    = 1'b1;
                        wr.end_d     = lo_reg;
                        chg_next     = 1'b1;
                        nlo_next     = hi_reg;
                        nhi_next     = rd_end;
                        nest_next    = 1'b1;
                        match_next   = 1'b0;
                        free_ok_next = 1'b0;
                        idx_next     = '0;
                        state_next   = ST_ADD;
                    end else begin
                        idx_next   = last ? '0 : idx_reg + idx_t'(1);
                        state_next = last ? ST_DONE : ST_SUB;
                    end
                end
            end

            ST_QUERY, ST_SIZE: begin
                if (!ph_reg) begin
                    if (valid[idx_reg]) begin
                        rd_en   = 1'b1;
                        ph_next = 1'b1;
                    end else begin
                        idx_next   = last ? '0 : idx_reg + idx_t'(1);
                        state_next = last ? ST_DONE : state_reg;
                    end
                end else begin
                    if (state_reg == ST_QUERY) begin
                        hit_next = hit_reg | cmp.hit;
                    end else begin
                        size_next = size_reg + cmp.diff;
                    end
                    ph_next    = 1'b0;
                    idx_next   = last ? '0 : idx_reg + idx_t'(1);
                    state_next = last ? ST_DONE : state_reg;
                end
            end

            ST_DONE: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    m_size_next  = size_reg;
                    m_used_next  = count;
                    if (act_reg == ACT_QUERY || act_reg == ACT_SIZE) begin
                        m_status_next = STS_DONE;
                    end else if (drop_reg) begin
                        m_status_next = STS_FULL;
                    end else if (chg_reg) begin
                        m_status_next = STS_DONE;
                    end else begin
                        m_status_next = STS_NOCHG;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        idx_reg      <= idx_next;
        ph_reg       <= ph_next;
        pass_reg     <= pass_next;
        match_reg    <= match_next;
        chg_reg      <= chg_next;
        drop_reg     <= drop_next;
        free_ok_reg  <= free_ok_next;
        free_idx_reg <= free_idx_next;
        nest_reg     <= nest_next;
        hit_reg      <= hit_next;
        size_reg     <= size_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        nlo_reg      <= nlo_next;
        nhi_reg      <= nhi_next;
        m_hit_reg    <= m_hit_next;
        m_status_reg <= m_status_next;
        m_size_reg   <= m_size_next;
        m_used_reg   <= m_used_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_status       = m_status_reg;
    assign m_total_size   = FIELD_W'(m_size_reg);
    assign m_entries_used = m_used_reg;

endmodule

FILE: dv/ars_checker.sv
// Checker for the address range set table: predicts each result beat and compares it.
`timescale 1ns / 1ps

module ars_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [1:0]    s_action,
    input  logic [63:0]   s_range_start,
    input  logic [63:0]   s_range_end,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic          m_hit,
    input  logic [1:0]    m_status,
    input  logic [63:0]   m_total_size,
    input  ars_pkg::cnt_t m_entries_used,
    output int            fail_count,
    output int            pending,
    output int            results_seen,
    output int            splits_seen,
    output int            fulls_seen
);
    import ars_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [1:0]  status;
        logic [63:0] total_size;
        cnt_t        used;
    } outcome_t;

    bit    tbl_valid [TABLE_ENTRIES];
    addr_t tbl_start [TABLE_ENTRIES];
    addr_t tbl_end   [TABLE_ENTRIES];
    outcome_t expected_q[$];

    function automatic int used_slots();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) if (tbl_valid[i]) n++;
        return n;
    endfunction

    function automatic status_t merge_range(addr_t lo, addr_t hi);
        bit matched, changed;
        addr_t s, e, ns, ne;
        matched = 0;
        changed = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i]) continue;
            s = tbl_start[i]; e = tbl_end[i]; ns = s; ne = e;
            if (s == lo && e == hi) begin
                matched = 1;
            end else if (s <= lo && e >= lo && e <= hi) begin
                ne = hi; matched = 1;
            end else if (s >= lo && s <= hi && e >= hi) begin
                ns = lo; matched = 1;
            end else if (s <= lo && e >= hi) begin
                matched = 1;
            end else if (s >= lo && s <= hi && e <= hi) begin
                ns = lo; ne = hi; matched = 1;
            end
            if (ns != s || ne != e) changed = 1;
            tbl_start[i] = ns;
            tbl_end[i] = ne;
        end
        if (!matched) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    tbl_valid[i] = 1; tbl_start[i] = lo; tbl_end[i] = hi;
                    return STS_DONE;
                end
            end
            return STS_FULL;
        end
        return changed ? STS_DONE : STS_NOCHG;
    endfunction

    function automatic status_t carve_range(addr_t lo, addr_t hi);
        bit changed, dropped, again;
        addr_t s, e;
        changed = 0;
        dropped = 0;
        if (lo == hi) return STS_NOCHG;
        for (int p = 0; p < RESCAN_CAP; p++) begin
            again = 0;
            for (int i = 0; i < TABLE_ENTRIES && !again; i++) begin
                if (!tbl_valid[i]) continue;
                s = tbl_start[i]; e = tbl_end[i];
                if (s < lo && e > lo && e < hi) begin
                    tbl_end[i] = lo; changed = 1;
                end else if (s > lo && s < hi && e > hi) begin
                    tbl_start[i] = hi; changed = 1;
                end
                s = tbl_start[i]; e = tbl_end[i];
                if (s > lo && s < hi && e > lo && e < hi) begin
                    tbl_valid[i] = 0; changed = 1; again = 1;
                end else if (s < lo && e > hi) begin
                    // split: keep the lower piece, re-add the upper one
                    tbl_end[i] = lo; changed = 1; again = 1;
                    splits_seen++;
                    if (merge_range(hi, e) == STS_FULL) dropped = 1;
                end
            end
            if (!again) break;
        end
        if (dropped) return STS_FULL;
        return changed ? STS_DONE : STS_NOCHG;
    endfunction

    function automatic outcome_t predict_op(action_t act, addr_t a, addr_t b);
        outcome_t r;
        addr_t lo, hi;
        r = '0;
        lo = a < b ? a : b;
        hi = a < b ? b : a;
        case (act)
            ACT_ADD: r.status = merge_range(lo, hi);
            ACT_SUB: r.status = carve_range(lo, hi);
            ACT_QUERY: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_valid[i] && a >= tbl_start[i] && a <= tbl_end[i]) r.hit = 1;
            end
            default: begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_valid[i]) r.total_size += tbl_end[i] - tbl_start[i];
            end
        endcase
        r.used = cnt_t'(used_slots());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0; results_seen = 0; splits_seen = 0; fulls_seen = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 0;
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        outcome_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t result beat with nothing expected", $time);
                    fail_count++;
                end else begin
                    w = expected_q.pop_front();
                    if (w.status == STS_FULL) fulls_seen++;
                    if (m_hit !== w.hit) report_mismatch("hit", m_hit, w.hit);
                    if (m_status !== w.status) report_mismatch("status", m_status, w.status);
                    if (m_total_size !== w.total_size)
                        report_mismatch("total_size", m_total_size, w.total_size);
                    if (m_entries_used !== w.used)
                        report_mismatch("entries_used", m_entries_used, w.used);
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(predict_op(action_t'(s_action), s_range_start,
                                                s_range_end));
        end
    end

endmodule

FILE: dv/tb_address_range_set_table.sv
// Testbench top for the address range set table: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_address_range_set_table;
    import ars_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_QUERY;
    logic [63:0] s_range_start = '0;
    logic [63:0] s_range_end = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_hit;
    logic [1:0]  m_status;
    logic [63:0] m_total_size;
    cnt_t        m_entries_used;

    int fail_count, pending, results_seen, splits_seen, fulls_seen;
    int send_idle_pct, recv_idle_pct;
    int quiet_cycles;
    int ops_sent;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    address_range_set_table uut (.*);

    ars_checker chk (.*);

    // Receiver: drop ready at random according to the current phase.
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Present one beat, hold it until taken, then maybe idle a while.
    task automatic send_op(action_t act, logic [63:0] a, logic [63:0] b);
        s_valid <= 1;
        s_action <= act;
        s_range_start <= a;
        s_range_end <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        ops_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            s_action <= action_t'($urandom_range(3));
            s_range_start <= {$urandom, $urandom};
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Random bound: mostly from a narrow window so ranges overlap, sometimes full width.
    function automatic logic [63:0] pick_addr(logic [63:0] base);
        case ($urandom_range(9))
            0:       return {$urandom, $urandom};
            1:       return $urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
            default: return base + $urandom_range(400);
        endcase
    endfunction

    task automatic random_ops(int count);
        logic [63:0] base, a, b;
        action_t act;
        for (int n = 0; n < count; n++) begin
            if (n % 200 == 0) base = {$urandom, $urandom};
            a = pick_addr(base);
            b = $urandom_range(3) == 0 ? a + $urandom_range(3) : pick_addr(base);
            case ($urandom_range(9))
                0, 1, 2, 3: act = ACT_ADD;
                4, 5, 6:    act = ACT_SUB;
                7, 8:       act = ACT_QUERY;
                default:    act = ACT_SIZE;
            endcase
            send_op(act, a, b);
        end
    endtask

    initial begin
        logic [63:0] top;
        top = 64'hFFFF_FFFF_FFFF_FFFF;
        quiet_cycles = 0;
        ops_sent = 0;
        send_idle_pct = 18;
        recv_idle_pct = 48;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: extremes, every action, swapped bounds, split, empty subtract.
        send_op(ACT_QUERY, 64'd0, 64'd0);
        send_op(ACT_SIZE, 64'd0, 64'd0);
        send_op(ACT_ADD, 64'd200, 64'd100);
        send_op(ACT_ADD, 64'd100, 64'd200);
        send_op(ACT_ADD, 64'd150, 64'd300);
        send_op(ACT_ADD, 64'd50, 64'd120);
        send_op(ACT_ADD, 64'd0, top);
        send_op(ACT_QUERY, top, 64'd0);
        send_op(ACT_SIZE, 64'd0, 64'd0);
        send_op(ACT_SUB, 64'd500, 64'd500);
        send_op(ACT_SUB, 64'd1000, 64'd2000);
        send_op(ACT_QUERY, 64'd1500, 64'd0);
        send_op(ACT_QUERY, 64'd2000, 64'd0);
        send_op(ACT_SUB, top, 64'd0);
        send_op(ACT_SUB, 64'd0, 64'd1);
        // Add 17 disjoint ranges; they fall inside the upper entry left by the split and merge away.
        for (int i = 0; i < 17; i++)
            send_op(ACT_ADD, 64'd10 * i + 5000, 64'd10 * i + 5003);
        // Subtract inside an entry: splits it and re-adds the upper piece.
        send_op(ACT_SUB, 64'd5001, 64'd5002);
        send_op(ACT_SIZE, 64'd0, 64'd0);
        // Broad subtract splits the upper entry again.
        send_op(ACT_SUB, 64'd5004, 64'd5200);
        send_op(ACT_QUERY, 64'd5003, 64'd0);

        random_ops(550);
        send_idle_pct = 48;
        recv_idle_pct = 18;
        random_ops(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_ops(500);

        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d operations, checked %0d results.", ops_sent, results_seen);
        $display("Splits predicted: %0d, table-full results: %0d.", splits_seen, fulls_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
